@@ design/krts_pkg.sv @@
// Package with the shared types and codes of the keyed record table.
`default_nettype none
package krts_pkg;
    typedef enum logic [2:0] {
        CMD_INSERT  = 3'd0,
        CMD_DISPLAY = 3'd1,
        CMD_SEARCH  = 3'd2,
        CMD_SORT    = 3'd3,
        CMD_DELETE  = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_DUP   = 3'd1,
        ST_NONE  = 3'd2,
        ST_FULL  = 3'd3,
        ST_EMPTY = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND,
        S_INS,
        S_DEL_RD,
        S_DEL_WR,
        S_SORT_KEY,
        S_SORT_CMP,
        S_SORT_WR,
        S_STREAM,
        S_EMIT,
        S_WAIT
    } fsm_t;

    localparam int REC_W = 96;
    typedef logic [REC_W-1:0] rec_t;

    function automatic logic [31:0] cost_of(input rec_t r);
        return r[31:0];
    endfunction

    function automatic logic [31:0] code_of(input rec_t r);
        return r[95:64];
    endfunction
endpackage
`default_nettype wire

@@ design/krts_ram.sv @@
// Record memory: one write port, one registered read port.
`default_nettype none
module krts_ram
    import krts_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW = 4
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire rec_t          wdata,
    input  wire logic [AW-1:0] raddr,
    output rec_t               rdata
);
    rec_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ design/keyed_record_table_sort.sv @@
// Top level of the keyed record table: command sequencer around one record memory.
// Usage
//   Input channel (valid/ready): command, item_code, item_quantity, item_cost.
//   Output channel (valid/ready): status, entry_index, out_code, out_quantity,
//   out_cost, last. Insert, search and delete give one item, display and sort
//   give one per record (or one table-empty item); the final item carries last.
//   Records sit in one synchronous memory of TABLE_DEPTH entries, one read per
//   cycle through a registered read port, so each step that looks at a record
//   costs a read slot.
// Operation
//   Insert, search and delete scan the table; delete then shifts the records
//   above the match down one place. Display reads and emits the records in
//   order. Sort is an insertion sort on the memory, followed by the display
//   pass. Undefined command codes are dropped and give no item.
//   One command is worked on at a time; in_ready is high only while idle with
//   no result waiting in the output register.
// Reset
//   rst_n clears the record count and sequencer; the table reads empty. Memory
//   contents are not cleared, entries past the count are never used.
// Stall
//   A result waits in the output register while out_valid is high and
//   out_ready is low; the sequencer holds until it is taken.
`default_nettype none
module keyed_record_table_sort
    import krts_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  command,
    input  wire logic [31:0] item_code,
    input  wire logic [31:0] item_quantity,
    input  wire logic [31:0] item_cost,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [3:0]       entry_index,
    output logic [31:0]      out_code,
    output logic [31:0]      out_quantity,
    output logic [31:0]      out_cost,
    output logic             last
);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    fsm_t state_reg, state_next;
    logic [2:0]    cmd_reg, cmd_next;
    logic [31:0]   key_reg, key_next;
    rec_t          item_reg, item_next;      // pending insert or sort key record
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] i_reg, i_next;            // scan / outer index
    logic [CW-1:0] j_reg, j_next;            // sort hole position
    logic          rd_pend_reg, rd_pend_next; // read issued last cycle

    logic             ov_reg, ov_next;
    logic [2:0]       st_reg, st_next;
    logic [3:0]       ix_reg, ix_next;
    rec_t             rec_reg, rec_next;
    logic             last_reg, last_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    rec_t          wdata, rdata;

    krts_ram #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    // hold off new commands until the last result has left the output register
    assign in_ready     = (state_reg == S_IDLE) && !ov_reg;
    assign out_valid    = ov_reg;
    assign status       = st_reg;
    assign entry_index  = ix_reg;
    assign out_code     = rec_reg[95:64];
    assign out_quantity = rec_reg[63:32];
    assign out_cost     = rec_reg[31:0];
    assign last         = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            ov_reg      <= 1'b0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ov_reg      <= ov_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        key_reg  <= key_next;
        item_reg <= item_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        st_reg   <= st_next;
        ix_reg   <= ix_next;
        rec_reg  <= rec_next;
        last_reg <= last_next;
    end

    // signed compare: prior cost greater than the key
    logic cost_gt;
    assign cost_gt = $signed(cost_of(rdata)) > $signed(cost_of(item_reg));

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        key_next     = key_reg;
        item_next    = item_reg;
        count_next   = count_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        rd_pend_next = 1'b0;
        ov_next      = ov_reg;
        st_next      = st_reg;
        ix_next      = ix_reg;
        rec_next     = rec_reg;
        last_next    = last_reg;
        we           = 1'b0;
        waddr        = i_reg[AW-1:0];
        wdata        = item_reg;
        raddr        = i_reg[AW-1:0];

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd_next  = command;
                    key_next  = item_code;
                    item_next = {item_code, item_quantity, item_cost};
                    i_next    = '0;
                    priority case (command)
                        CMD_INSERT, CMD_SEARCH, CMD_DELETE: state_next = S_FIND;
                        CMD_DISPLAY: state_next = S_STREAM;
                        CMD_SORT:
                        begin
                            i_next     = CW'(1);
                            state_next = S_SORT_KEY;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end

            // issue a read at i, check the returned entry the cycle after
            S_FIND:
            begin
                if (rd_pend_reg && code_of(rdata) == key_reg)
                begin
                    // match at i-1
                    ix_next  = 4'(i_reg - CW'(1));
                    rec_next = rdata;
                    last_next = 1'b1;
                    priority case (cmd_reg)
                        CMD_INSERT:
                        begin
                            st_next    = ST_DUP;
                            state_next = S_EMIT;
                        end
                        CMD_SEARCH:
                        begin
                            st_next    = ST_OK;
                            state_next = S_EMIT;
                        end
                        default:
                        begin
                            st_next    = ST_OK;
                            i_next     = i_reg - CW'(1);
                            state_next = S_DEL_RD;
                        end
                    endcase
                end
                else if (i_reg >= count_reg)
                begin
                    last_next = 1'b1;
                    if (cmd_reg == CMD_INSERT)
                    begin
                        if (count_reg >= CW'(TABLE_DEPTH))
                        begin
                            st_next    = ST_FULL;
                            ix_next    = '0;
                            rec_next   = '0;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_INS;
                        end
                    end
                    else
                    begin
                        st_next    = ST_NONE;
                        ix_next    = '0;
                        rec_next   = '0;
                        state_next = S_EMIT;
                    end
                end
                else
                begin
                    rd_pend_next = 1'b1;
                    i_next       = i_reg + CW'(1);
                end
            end

            S_INS:
            begin
                we         = 1'b1;
                waddr      = count_reg[AW-1:0];
                wdata      = item_reg;
                count_next = count_reg + CW'(1);
                st_next    = ST_OK;
                ix_next    = 4'(count_reg);
                rec_next   = item_reg;
                state_next = S_EMIT;
            end

            // shift entries above i down one place
            S_DEL_RD:
            begin
                if (i_reg + CW'(1) >= count_reg)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_EMIT;
                end
                else
                begin
                    raddr      = AW'(i_reg + CW'(1));
                    state_next = S_DEL_WR;
                end
            end

            S_DEL_WR:
            begin
                we         = 1'b1;
                waddr      = i_reg[AW-1:0];
                wdata      = rdata;
                i_next     = i_reg + CW'(1);
                state_next = S_DEL_RD;
            end

            // fetch record i as the key, hole at i
            S_SORT_KEY:
            begin
                if (i_reg >= count_reg)
                begin
                    i_next     = '0;
                    state_next = S_STREAM;
                end
                else if (!rd_pend_reg)
                begin
                    rd_pend_next = 1'b1;
                end
                else
                begin
                    item_next  = rdata;
                    j_next     = i_reg;
                    raddr      = AW'(i_reg - CW'(1));
                    state_next = S_SORT_CMP;
                end
            end

            // rdata holds entry j-1
            S_SORT_CMP:
            begin
                if (cost_gt)
                begin
                    we         = 1'b1;
                    waddr      = j_reg[AW-1:0];
                    wdata      = rdata;
                    j_next     = j_reg - CW'(1);
                    if (j_reg == CW'(1))
                    begin
                        state_next = S_SORT_WR;
                    end
                    else
                    begin
                        raddr      = AW'(j_reg - CW'(2));
                        state_next = S_SORT_CMP;
                    end
                end
                else
                begin
                    state_next = S_SORT_WR;
                end
            end

            S_SORT_WR:
            begin
                we         = 1'b1;
                waddr      = j_reg[AW-1:0];
                wdata      = item_reg;
                i_next     = i_reg + CW'(1);
                state_next = S_SORT_KEY;
            end

            S_STREAM:
            begin
                if (count_reg == '0)
                begin
                    st_next    = ST_EMPTY;
                    ix_next    = '0;
                    rec_next   = '0;
                    last_next  = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    raddr      = i_reg[AW-1:0];
                    state_next = S_WAIT;
                end
            end

            // data for entry i is on rdata; hold until output register free
            S_WAIT:
            begin
                raddr = i_reg[AW-1:0];
                if (!ov_reg || out_ready)
                begin
                    ov_next   = 1'b1;
                    st_next   = ST_OK;
                    ix_next   = 4'(i_reg);
                    rec_next  = rdata;
                    last_next = (i_reg + CW'(1) == count_reg);
                    i_next    = i_reg + CW'(1);
                    state_next = (i_reg + CW'(1) == count_reg) ? S_IDLE : S_WAIT;
                end
                else
                begin
                    state_next = S_WAIT;
                end
                if (state_next == S_WAIT && (!ov_reg || out_ready))
                begin
                    raddr      = AW'(i_reg + CW'(1));
                    state_next = S_STREAM;
                    i_next     = i_reg + CW'(1);
                end
            end

            S_EMIT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

@@ test/tb.sv @@
// Testbench of the keyed record table: random commands checked against a table predictor.
`timescale 1ns / 100ps
module tb;
    import krts_pkg::*;

    localparam int DEPTH = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] code;
        logic [31:0] qty;
        logic [31:0] cost;
    } request_t;

    typedef struct packed {
        logic [2:0]  st;
        logic [3:0]  idx;
        logic [31:0] code;
        logic [31:0] qty;
        logic [31:0] cost;
        logic        lst;
    } record_report_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  command;
    logic [31:0] item_code;
    logic [31:0] item_quantity;
    logic [31:0] item_cost;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [3:0]  entry_index;
    logic [31:0] out_code;
    logic [31:0] out_quantity;
    logic [31:0] out_cost;
    logic        last;

    keyed_record_table_sort #(.TABLE_DEPTH(DEPTH)) DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .item_code(item_code),
        .item_quantity(item_quantity), .item_cost(item_cost),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .entry_index(entry_index),
        .out_code(out_code), .out_quantity(out_quantity),
        .out_cost(out_cost), .last(last)
    );

    // Predicted copy of the table
    logic [31:0] tbl_code [DEPTH];
    logic [31:0] tbl_qty  [DEPTH];
    logic [31:0] tbl_cost [DEPTH];
    int          tbl_count;

    request_t       pending_requests[$];
    record_report_t expected_reports[$];
    int             mismatch_count;
    int             report_count;
    int             request_count;
    int             idle_cycles;
    bit             stimulus_done;
    bit             hold_off;

    // Known codes, so that random searches, deletes and duplicates hit often
    logic [31:0] used_codes[$];

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int find_code(logic [31:0] c);
        for (int i = 0; i < tbl_count; i++)
            if (tbl_code[i] == c)
                return i;
        return -1;
    endfunction

    task automatic push_report(status_t s, int i, logic [31:0] c, logic [31:0] q,
                               logic [31:0] k, bit l);
        record_report_t r;
        r.st = s;
        r.idx = i[3:0];
        r.code = c;
        r.qty = q;
        r.cost = k;
        r.lst = l;
        expected_reports = {expected_reports, r};
    endtask

    task automatic stream_table();
        if (tbl_count == 0)
            push_report(ST_EMPTY, 0, '0, '0, '0, 1'b1);
        else
            for (int i = 0; i < tbl_count; i++)
                push_report(ST_OK, i, tbl_code[i], tbl_qty[i], tbl_cost[i],
                            i == tbl_count - 1);
    endtask

    // Work out the reports that one accepted request causes
    task automatic predict_table(request_t r);
        int p;
        logic [31:0] c, q, k;
        int j;
        p = find_code(r.code);
        case (r.cmd)
            CMD_INSERT:
                if (p >= 0)
                    push_report(ST_DUP, p, tbl_code[p], tbl_qty[p], tbl_cost[p], 1'b1);
                else if (tbl_count >= DEPTH)
                    push_report(ST_FULL, 0, '0, '0, '0, 1'b1);
                else
                begin
                    tbl_code[tbl_count] = r.code;
                    tbl_qty[tbl_count] = r.qty;
                    tbl_cost[tbl_count] = r.cost;
                    push_report(ST_OK, tbl_count, r.code, r.qty, r.cost, 1'b1);
                    tbl_count++;
                end
            CMD_DISPLAY:
                stream_table();
            CMD_SEARCH:
                if (p >= 0)
                    push_report(ST_OK, p, tbl_code[p], tbl_qty[p], tbl_cost[p], 1'b1);
                else
                    push_report(ST_NONE, 0, '0, '0, '0, 1'b1);
            CMD_SORT:
            begin
                // stable insertion sort on signed cost
                for (int i = 1; i < tbl_count; i++)
                begin
                    c = tbl_code[i];
                    q = tbl_qty[i];
                    k = tbl_cost[i];
                    j = i;
                    while (j > 0 && $signed(tbl_cost[j-1]) > $signed(k))
                    begin
                        tbl_code[j] = tbl_code[j-1];
                        tbl_qty[j] = tbl_qty[j-1];
                        tbl_cost[j] = tbl_cost[j-1];
                        j--;
                    end
                    tbl_code[j] = c;
                    tbl_qty[j] = q;
                    tbl_cost[j] = k;
                end
                stream_table();
            end
            CMD_DELETE:
                if (p < 0)
                    push_report(ST_NONE, 0, '0, '0, '0, 1'b1);
                else
                begin
                    push_report(ST_OK, p, tbl_code[p], tbl_qty[p], tbl_cost[p], 1'b1);
                    for (int i = p; i + 1 < tbl_count; i++)
                    begin
                        tbl_code[i] = tbl_code[i+1];
                        tbl_qty[i] = tbl_qty[i+1];
                        tbl_cost[i] = tbl_cost[i+1];
                    end
                    tbl_count--;
                end
            default: ;
        endcase
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_code();
        if (used_codes.size() > 0 && $urandom_range(0, 3) != 0)
            return used_codes[$urandom_range(0, used_codes.size() - 1)];
        return rand_word();
    endfunction

    task automatic queue_request(cmd_t c, logic [31:0] code, logic [31:0] q,
                                 logic [31:0] k);
        request_t r;
        r.cmd = c;
        r.code = code;
        r.qty = q;
        r.cost = k;
        pending_requests = {pending_requests, r};
        if (c == CMD_INSERT)
            used_codes = {used_codes, code};
    endtask

    // Stimulus: directed opening, then random traffic
    initial begin
        request_t r;
        int pick;
        // empty table cases
        queue_request(CMD_DISPLAY, 0, 0, 0);
        queue_request(CMD_SORT, 0, 0, 0);
        queue_request(CMD_SEARCH, 5, 0, 0);
        queue_request(CMD_DELETE, 5, 0, 0);
        // field extremes, equal costs for sort stability
        queue_request(CMD_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_request(CMD_INSERT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        queue_request(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0005);
        queue_request(CMD_INSERT, 32'h0, 32'h0, 32'h0000_0005);
        queue_request(CMD_INSERT, 32'h7FFF_FFFF, 1, 2);
        queue_request(CMD_SEARCH, 32'hFFFF_FFFF, 0, 0);
        queue_request(CMD_SORT, 0, 0, 0);
        queue_request(CMD_DELETE, 32'h8000_0000, 0, 0);
        queue_request(CMD_DISPLAY, 0, 0, 0);
        // undefined commands are ignored
        r = '0;
        r.cmd = 3'd5;
        pending_requests = {pending_requests, r};
        r.cmd = 3'd7;
        r.code = '1;
        pending_requests = {pending_requests, r};
        // fill to full, then one more
        for (int i = 0; i < 13; i++)
            queue_request(CMD_INSERT, 32'h100 + i, $urandom, $urandom);
        queue_request(CMD_INSERT, 32'h55, 1, 1);
        queue_request(CMD_SORT, 0, 0, 0);
        // random part
        for (int i = 0; i < 220; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                queue_request(CMD_INSERT, pick_code(), rand_word(), rand_word());
            else if (pick < 60)
                queue_request(CMD_DELETE, pick_code(), rand_word(), rand_word());
            else if (pick < 78)
                queue_request(CMD_SEARCH, pick_code(), rand_word(), rand_word());
            else if (pick < 86)
                queue_request(CMD_DISPLAY, rand_word(), rand_word(), rand_word());
            else if (pick < 94)
                queue_request(CMD_SORT, rand_word(), rand_word(), rand_word());
            else
            begin
                r.cmd = 3'($urandom_range(5, 7));
                r.code = $urandom;
                r.qty = $urandom;
                r.cost = $urandom;
                pending_requests = {pending_requests, r};
            end
        end
    end

    // Driver: bursts and gaps; hold valid and payload until accepted
    int burst_left;
    int gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            command <= '0;
            item_code <= '0;
            item_quantity <= '0;
            item_cost <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_table({command, item_code, item_quantity, item_cost});
                request_count++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_requests.size() > 0)
                begin
                    {command, item_code, item_quantity, item_cost}
                        <= pending_requests.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left == 0)
                    begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern; a long hold-off forces the input to back up
    int stall_phase;
    int hold_cycles;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_phase <= 0;
            hold_cycles <= 0;
        end
        else
        begin
            stall_phase <= stall_phase + 1;
            if (report_count >= 60 && hold_cycles == 0)
                hold_cycles <= 400;
            else if (hold_cycles > 1)
                hold_cycles <= hold_cycles - 1;
            if (hold_cycles > 1)
                out_ready <= 1'b0;
            else if (stall_phase[8])
                out_ready <= 1'b1;
            else
                out_ready <= (stall_phase % 7 != 3) && ($urandom_range(0, 3) != 0);
        end
    end

    // Monitor: compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            record_report_t got;
            record_report_t want;
            got = {status, entry_index, out_code, out_quantity, out_cost, last};
            report_count++;
            if (expected_reports.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %h", got);
            end
            else
            begin
                want = expected_reports.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: expected st=%0d idx=%0d code=%h qty=%h ",
                                  "cost=%h last=%b, got st=%0d idx=%0d code=%h qty=%h ",
                                  "cost=%h last=%b"},
                                 want.st, want.idx, want.code, want.qty, want.cost,
                                 want.lst, got.st, got.idx, got.code, got.qty,
                                 got.cost, got.lst);
                end
            end
        end
    end

    // Watchdog: count cycles with no accepted item on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired: %0d results still due", expected_reports.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        mismatch_count = 0;
        report_count = 0;
        request_count = 0;
        idle_cycles = 0;
        tbl_count = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        command = '0;
        item_code = '0;
        item_quantity = '0;
        item_cost = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_requests.size() == 0 && !in_valid);
        wait (expected_reports.size() == 0);
        repeat (200) @(posedge clk);
        $display("run covered %0d commands and %0d checked results", request_count,
                 report_count);
        if (mismatch_count == 0 && expected_reports.size() == 0)
            $display("end of test: clean");
        else
        begin
            $display("%0d mismatches, %0d results missing", mismatch_count,
                     expected_reports.size());
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
